[rtl/core/fkhe_pkg.sv]
// Shared types and constants for the flow key header extractor.
package fkhe_pkg;

    localparam int LINK_HEADER_BYTES_DEF = 14;
    localparam int OFFSET_BITS_DEF       = 7;

    localparam int          NS_PER_US = 1000;
    localparam logic [15:0] KIND_IPV4 = 16'h0800;

    typedef enum logic [7:0] {
        P_ICMP = 8'd1,
        P_TCP  = 8'd6,
        P_UDP  = 8'd17
    } t_proto;

    // One byte request from the link side.
    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [31:0] stamp_sec;
        logic [19:0] stamp_usec;
    } t_in_item;

    // One flow record.
    typedef struct packed {
        logic [4:0]  proto_code;
        logic [7:0]  type_of_service;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [3:0]  header_words;
        logic [15:0] datagram_length;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] time_seconds;
        logic [29:0] time_nanos;
    } t_flow_record;

    // Captured header fields, handed from capture to record build.
    typedef struct packed {
        logic [15:0] ether_kind;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len;
        logic [7:0]  flags;
    } t_held;

endpackage

[rtl/core/fkhe_if.sv]
// Handshake channels of the flow key header extractor.
interface fkhe_in_if import fkhe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fkhe_out_if import fkhe_pkg::*; ();
    logic         valid;
    logic         ready;
    t_flow_record data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/fkhe_capture.sv]
// Byte offset tracking and header field capture.
module fkhe_capture import fkhe_pkg::*; #(
    parameter int LINK_HEADER_BYTES = LINK_HEADER_BYTES_DEF,
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_frame_byte,
    input  logic       i_last_byte,
    output t_held      o_held
);

    // one spare bit so L4 positions never wrap
    localparam int PW = OFFSET_BITS + 1;
    localparam logic [PW-1:0] IP = PW'(LINK_HEADER_BYTES);

    logic [OFFSET_BITS-1:0] r_offset;
    logic [OFFSET_BITS-1:0] n_offset;
    t_held                  r_held;
    t_held                  cap;
    logic [PW-1:0]          off;
    logic [3:0]             ihl_now;
    logic [PW-1:0]          l4;

    always_comb begin
        cap     = r_held;
        off     = {1'b0, r_offset};
        // IHL byte already places L4 for itself
        ihl_now = (off == IP) ? i_frame_byte[3:0] : r_held.ihl;
        l4      = IP + PW'({ihl_now, 2'b00});

        if (off == IP - PW'(2)) cap.ether_kind[15:8] = i_frame_byte;
        if (off == IP - PW'(1)) cap.ether_kind[7:0]  = i_frame_byte;
        if (off == IP)          cap.ihl              = i_frame_byte[3:0];
        if (off == IP + PW'(1)) cap.tos              = i_frame_byte;
        if (off == IP + PW'(2)) cap.len[15:8]        = i_frame_byte;
        if (off == IP + PW'(3)) cap.len[7:0]         = i_frame_byte;
        if (off == IP + PW'(9)) cap.proto            = i_frame_byte;
        if (off == IP + PW'(12)) cap.src[31:24]      = i_frame_byte;
        if (off == IP + PW'(13)) cap.src[23:16]      = i_frame_byte;
        if (off == IP + PW'(14)) cap.src[15:8]       = i_frame_byte;
        if (off == IP + PW'(15)) cap.src[7:0]        = i_frame_byte;
        if (off == IP + PW'(16)) cap.dst[31:24]      = i_frame_byte;
        if (off == IP + PW'(17)) cap.dst[23:16]      = i_frame_byte;
        if (off == IP + PW'(18)) cap.dst[15:8]       = i_frame_byte;
        if (off == IP + PW'(19)) cap.dst[7:0]        = i_frame_byte;
        if (off == l4)           cap.sport[15:8]     = i_frame_byte;
        if (off == l4 + PW'(1))  cap.sport[7:0]      = i_frame_byte;
        if (off == l4 + PW'(2))  cap.dport[15:8]     = i_frame_byte;
        if (off == l4 + PW'(3))  cap.dport[7:0]      = i_frame_byte;
        if (off == l4 + PW'(13)) cap.flags           = i_frame_byte;

        // saturate at all ones
        n_offset = (&r_offset) ? r_offset : r_offset + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_held   <= '0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_offset <= '0;
                r_held   <= '0;
            end else begin
                r_offset <= n_offset;
                r_held   <= cap;
            end
        end
    end

    assign o_held = cap;

endmodule

[rtl/core/fkhe_emit.sv]
// Flow record build and output register.
module fkhe_emit import fkhe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  t_held        i_held,
    input  logic [31:0]  i_stamp_sec,
    input  logic [19:0]  i_stamp_usec,
    input  logic         i_out_ready,
    output logic         o_space,
    output logic         o_valid,
    output t_flow_record o_rec
);

    logic         r_valid;
    t_flow_record r_rec;
    t_flow_record n_rec;
    logic         tcp;
    logic         udp;
    logic         known;

    always_comb begin
        tcp   = (i_held.proto == P_TCP);
        udp   = (i_held.proto == P_UDP);
        known = (i_held.ether_kind == KIND_IPV4) && (tcp || udp || i_held.proto == P_ICMP);

        n_rec = '0;
        if (known) begin
            n_rec.proto_code      = i_held.proto[4:0];
            n_rec.type_of_service = i_held.tos;
            n_rec.source_address  = i_held.src;
            n_rec.dest_address    = i_held.dst;
            if (tcp || udp) begin
                n_rec.source_port = i_held.sport;
                n_rec.dest_port   = i_held.dport;
            end
            n_rec.header_words    = i_held.ihl;
            n_rec.datagram_length = i_held.len;
            if (tcp) begin
                n_rec.tcp_flag_bits = i_held.flags;
            end
        end
        n_rec.time_seconds = i_stamp_sec;
        // 20 x 10 bit product, exactly 30 bits
        n_rec.time_nanos   = 30'(i_stamp_usec) * 30'(NS_PER_US);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rec <= n_rec;
        end
    end

    assign o_space = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

[rtl/core/flow_key_header_extractor.sv]
// Top level of the flow key header extractor.
//
// Usage:
//   i_req  - byte channel: one Ethernet frame byte per request, wire order,
//            with a last-byte mark and the capture timestamp (seconds and
//            microseconds, sampled with the last byte only).
//   o_rec  - record channel: one flow record per frame, issued after the
//            request that carries the last byte.
// Output: the record is registered and is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle, sustained while the record channel keeps
//   up; the record register sits between the two channels, and a record
//   left waiting on o_rec holds off every byte request until it is taken.
// Stall: i_req.ready drops only while a record is pending and o_rec.ready
//   is low; a pending record holds steady until taken.
// Reset: synchronous, active low; clears the byte offset, all captured
//   fields and the record valid flag. No clearing pass is needed.
// Non-IPv4 frames, or protocols other than ICMP/TCP/UDP, give a record with
//   only the time fields set. Header fields a short frame never reached
//   read as zero. Past the top of the offset counter, bytes are ignored.
module flow_key_header_extractor import fkhe_pkg::*; #(
    parameter int LINK_HEADER_BYTES = LINK_HEADER_BYTES_DEF,
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fkhe_in_if.sink    i_req,
    fkhe_out_if.source o_rec
);

    logic  take;
    logic  fire;
    logic  space;
    t_held held;

    // a byte is taken whenever the record register can hold a new record
    assign i_req.ready = space;
    assign take        = i_req.valid && space;
    assign fire        = take && i_req.data.last_byte;

    // offset counter and field capture
    fkhe_capture #(
        .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_frame_byte (i_req.data.frame_byte),
        .i_last_byte  (i_req.data.last_byte),
        .o_held       (held)
    );

    // record build from the fields including the last byte, then register
    fkhe_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_held       (held),
        .i_stamp_sec  (i_req.data.stamp_sec),
        .i_stamp_usec (i_req.data.stamp_usec),
        .i_out_ready  (o_rec.ready),
        .o_space      (space),
        .o_valid      (o_rec.valid),
        .o_rec        (o_rec.data)
    );

endmodule

[rtl/core/fkhe_checker.sv]
// Port-level assertions for the flow key header extractor, with bind.
module fkhe_checker import fkhe_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_in_last,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input t_flow_record i_out_data
);

    a_last_gives_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("no record after last byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("byte channel stalled without pending record");

    a_record_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("pending record changed");

    a_proto_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.proto_code == 5'd0 ||
                         i_out_data.proto_code == 5'(P_ICMP) ||
                         i_out_data.proto_code == 5'(P_TCP) ||
                         i_out_data.proto_code == 5'(P_UDP)))
        else $error("bad protocol code");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.proto_code != 5'(P_TCP) |-> i_out_data.tcp_flag_bits == 8'd0)
        else $error("flags set on non-TCP record");

endmodule

bind flow_key_header_extractor fkhe_checker u_fkhe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_last   (i_req.data.last_byte),
    .i_out_valid (o_rec.valid),
    .i_out_ready (o_rec.ready),
    .i_out_data  (o_rec.data)
);
